// File: rtl/lts_pkg.sv
package lts_pkg;

    // Result kinds
    localparam logic [2:0] KIND_NUMBER  = 3'd0;
    localparam logic [2:0] KIND_KEYWORD = 3'd1;
    localparam logic [2:0] KIND_IDENT   = 3'd2;
    localparam logic [2:0] KIND_SPECIAL = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // Scanner modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_NAME   = 2'd2;

    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

    // Byte codes
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Keywords, first character in the low byte
    localparam int KW_COUNT = 10;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0072_6f66,   // for
        48'h0065_6c69_6877,   // while
        48'h0000_0000_6f64,   // do
        48'h0000_0074_6e69,   // int
        48'h0074_616f_6c66,   // float
        48'h0000_7261_6863,   // char
        48'h656c_6275_6f64,   // double
        48'h6674_6e69_7270,   // printf
        48'h6863_7469_7773,   // switch
        48'h0000_6573_6163    // case
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd3, 8'd5, 8'd2, 8'd3, 8'd5, 8'd4, 8'd6, 8'd6, 8'd6, 8'd4
    };

    // FIFO between scanner front and token back end
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One queued command: a flushed token and/or a second result
    typedef struct packed {
        logic        tok_vld;
        logic        tok_is_name;
        logic [30:0] tok_num;
        logic [63:0] name_chars;
        logic [7:0]  name_len;
        logic        sec_vld;
        logic        sec_is_end;
        logic [30:0] sec_val;     // line count, or special byte in low bits
    } t_cmd;

    typedef struct packed {
        logic       hit;
        logic [3:0] index;
    } t_kw_hit;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

    // Name buffer bytes past the count are always zero, so a padded
    // whole-word compare plus a length check is an exact match.
    function automatic t_kw_hit kw_lookup(input logic [63:0] chars, input logic [7:0] len);
        t_kw_hit r;
        r = '0;
        for (int w = KW_COUNT - 1; w >= 0; w--) begin
            if ((len == KW_LEN[w]) && (chars[63:48] == 16'h0000) &&
                (chars[47:0] == KW_TEXT[w])) begin
                r.hit   = 1'b1;
                r.index = 4'(w);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/lts_in_if.sv
interface lts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

// File: rtl/lts_out_if.sv
interface lts_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [30:0] value;
    logic [3:0]  keyword_index;
    logic [63:0] name_chars;
    logic [7:0]  name_length;
    logic [7:0]  special_char;
    logic        last;

    modport source (output valid, output kind, output value, output keyword_index,
                    output name_chars, output name_length, output special_char,
                    output last, input ready);
    modport sink   (input valid, input kind, input value, input keyword_index,
                    input name_chars, input name_length, input special_char,
                    input last, output ready);
endinterface

// File: rtl/lts_front.sv
module lts_front
    import lts_pkg::*;
#(
    parameter int NAME_CHARS = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lts_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    logic [1:0]  r_mode, n_mode;
    logic [30:0] r_acc,  n_acc;
    logic [63:0] r_buf,  n_buf;
    logic [7:0]  r_cnt,  n_cnt;
    logic [30:0] r_line, n_line;

    logic        acc;
    logic [7:0]  c;
    logic [34:0] acc_x10;
    logic        name_char;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && i_in.ready;
    assign c          = i_in.ch;
    assign acc_x10    = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {31'd0, c[3:0]};
    assign name_char  = is_letter(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOLLAR);

    // Next-state and command build
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        n_line = r_line;
        o_cmd  = '0;
        o_push = 1'b0;

        o_cmd.tok_is_name = (r_mode == MODE_NAME);
        o_cmd.tok_num     = r_acc;
        o_cmd.name_chars  = r_buf;
        o_cmd.name_len    = r_cnt;

        if (acc) begin
            if (i_in.is_end) begin
                o_cmd.tok_vld    = (r_mode != MODE_IDLE);
                o_cmd.sec_vld    = 1'b1;
                o_cmd.sec_is_end = 1'b1;
                o_cmd.sec_val    = r_line;
                o_push = 1'b1;
                n_mode = MODE_IDLE;
                n_acc  = '0;
                n_buf  = '0;
                n_cnt  = '0;
                n_line = 31'd1;
            end else if ((r_mode == MODE_NUMBER) && is_digit(c)) begin
                n_acc = (acc_x10 > {4'd0, SAT31}) ? SAT31 : acc_x10[30:0];
            end else if ((r_mode == MODE_NAME) && name_char) begin
                // store only the first NAME_CHARS characters
                for (int k = 0; k < 8; k++) begin
                    if ((k < NAME_CHARS) && (r_cnt == 8'(k))) begin
                        n_buf[k*8 +: 8] = c;
                    end
                end
                if (r_cnt != 8'hFF) begin
                    n_cnt = r_cnt + 8'd1;
                end
            end else begin
                // token (if any) ends here; the byte is handled itself
                o_cmd.tok_vld = (r_mode != MODE_IDLE);
                n_mode = MODE_IDLE;
                n_acc  = '0;
                n_buf  = '0;
                n_cnt  = '0;
                priority if (is_digit(c)) begin
                    n_mode = MODE_NUMBER;
                    n_acc  = {27'd0, c[3:0]};
                end else if (is_letter(c)) begin
                    n_mode = MODE_NAME;
                    n_buf  = {56'd0, c};
                    n_cnt  = 8'd1;
                end else if ((c == CH_SPACE) || (c == CH_TAB)) begin
                    // skipped
                end else if (c == CH_NEWLINE) begin
                    if (r_line != SAT31) begin
                        n_line = r_line + 31'd1;
                    end
                end else begin
                    o_cmd.sec_vld = 1'b1;
                    o_cmd.sec_val = {23'd0, c};
                end
                o_push = o_cmd.tok_vld || o_cmd.sec_vld;
            end
        end
    end

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_buf  <= '0;
            r_cnt  <= '0;
            r_line <= 31'd1;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_line <= n_line;
        end
    end

endmodule

// File: rtl/lts_fifo.sv
module lts_fifo
    import lts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QPTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/lts_back.sv
module lts_back
    import lts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_empty,
    output logic       o_pop,
    lts_out_if.source  o_tok
);

    logic        r_vld;
    logic        r_phase;
    logic [2:0]  r_kind;
    logic [30:0] r_value;
    logic [3:0]  r_kw;
    logic [63:0] r_chars;
    logic [7:0]  r_len;
    logic [7:0]  r_sp;
    logic        r_last;

    logic        load, emit, first;
    t_kw_hit     kw;

    assign load  = !r_vld || o_tok.ready;
    assign emit  = load && !i_empty;
    assign first = i_cmd.tok_vld && !r_phase;
    assign kw    = kw_lookup(i_cmd.name_chars, i_cmd.name_len);
    assign o_pop = emit && !(first && i_cmd.sec_vld);

    // Output register: token first, then the special or summary result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_vld   <= !i_empty;
            r_phase <= emit && first && i_cmd.sec_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value <= '0;
            r_kw    <= '0;
            r_chars <= '0;
            r_len   <= '0;
            r_sp    <= '0;
            if (first) begin
                r_last <= !i_cmd.sec_vld;
                if (!i_cmd.tok_is_name) begin
                    r_kind  <= KIND_NUMBER;
                    r_value <= i_cmd.tok_num;
                end else begin
                    r_kind  <= kw.hit ? KIND_KEYWORD : KIND_IDENT;
                    r_kw    <= kw.hit ? kw.index : 4'd0;
                    r_chars <= i_cmd.name_chars;
                    r_len   <= i_cmd.name_len;
                end
            end else begin
                r_last <= 1'b1;
                if (i_cmd.sec_is_end) begin
                    r_kind  <= KIND_END;
                    r_value <= i_cmd.sec_val;
                end else begin
                    r_kind <= KIND_SPECIAL;
                    r_sp   <= i_cmd.sec_val[7:0];
                end
            end
        end
    end

    assign o_tok.valid         = r_vld;
    assign o_tok.kind          = r_kind;
    assign o_tok.value         = r_value;
    assign o_tok.keyword_index = r_kw;
    assign o_tok.name_chars    = r_chars;
    assign o_tok.name_length   = r_len;
    assign o_tok.special_char  = r_sp;
    assign o_tok.last          = r_last;

endmodule

// File: rtl/lexical_token_scanner.sv
// Lexical token scanner for a small C subset.
// Input channel i_in carries one source byte (ch) or an end marker (is_end)
// per transfer. Output channel o_tok carries tokens: numbers, keywords,
// identifiers (first characters plus length), special characters, and an
// end summary with the line count. last marks the final token of an item.
// The front classifies each byte and updates the scan state in the cycle it
// is accepted; it queues a command only when the byte yields results. The
// back end does the keyword match and drives a registered output.
// A token reaches o_tok through the command queue and then the output register.
// Throughput: one byte per cycle while the queue has room; bytes that yield
// two tokens take two output transfers, absorbed by a 4-entry command queue.
// i_in.ready drops only when that queue is full, i.e. when the receiver has
// stalled o_tok or two-token bytes arrive faster than they drain.
// Reset (synchronous, active low) clears the scan state, sets the line
// count to 1 and empties the queue and output register.
module lexical_token_scanner
    import lts_pkg::*;
#(
    parameter int NAME_CHARS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lts_in_if.sink    i_in,
    lts_out_if.source o_tok
);

    logic push, pop, full, empty;
    t_cmd push_cmd, head_cmd;

    lts_front #(
        .NAME_CHARS (NAME_CHARS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    lts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    lts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_tok   (o_tok)
    );

    // Queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full) else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("command queue underflow");

    // End summary always closes its item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && (o_tok.kind == KIND_END)) |-> o_tok.last)
        else $error("end summary without last");

    // A queued command reaches an empty output register in the next cycle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_tok.valid) |=> o_tok.valid)
        else $error("queued command not emitted");

endmodule
